/* design/st_pkg.sv */
package st_pkg;

    localparam int MAX_RES = 8;
    localparam int CNT_W = $clog2(MAX_RES + 1);
    localparam int IDX_W = $clog2(MAX_RES);

    localparam logic [4:0] K_IDENT   = 5'd0;
    localparam logic [4:0] K_INT     = 5'd1;
    localparam logic [4:0] K_STR     = 5'd2;
    localparam logic [4:0] K_LPAREN  = 5'd3;
    localparam logic [4:0] K_RPAREN  = 5'd4;
    localparam logic [4:0] K_LBRACE  = 5'd5;
    localparam logic [4:0] K_RBRACE  = 5'd6;
    localparam logic [4:0] K_SEMI    = 5'd7;
    localparam logic [4:0] K_COMMA   = 5'd8;
    localparam logic [4:0] K_EQEQ    = 5'd9;
    localparam logic [4:0] K_ASSIGN  = 5'd10;
    localparam logic [4:0] K_PLUS    = 5'd11;
    localparam logic [4:0] K_MINUS   = 5'd12;
    localparam logic [4:0] K_STAR    = 5'd13;
    localparam logic [4:0] K_SLASH   = 5'd14;
    localparam logic [4:0] K_NE      = 5'd15;
    localparam logic [4:0] K_NOT     = 5'd16;
    localparam logic [4:0] K_LE      = 5'd17;
    localparam logic [4:0] K_LT      = 5'd18;
    localparam logic [4:0] K_GE      = 5'd19;
    localparam logic [4:0] K_GT      = 5'd20;
    localparam logic [4:0] K_OROR    = 5'd21;
    localparam logic [4:0] K_ANDAND  = 5'd22;
    localparam logic [4:0] K_PERCENT = 5'd23;
    localparam logic [4:0] K_EOF     = 5'd24;

    localparam logic [1:0] E_NONE   = 2'd0;
    localparam logic [1:0] E_CHAR   = 2'd1;
    localparam logic [1:0] E_STRING = 2'd2;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] value;
        logic       text;
        logic [1:0] err;
    } t_result;

    typedef t_result [MAX_RES-1:0] t_res_list;

    typedef enum logic [7:0] {
        M_IDLE  = 8'b0000_0001,
        M_IDENT = 8'b0000_0010,
        M_INT   = 8'b0000_0100,
        M_STR   = 8'b0000_1000,
        M_ESC   = 8'b0001_0000,
        M_OWE   = 8'b0010_0000,
        M_CMT   = 8'b0100_0000,
        M_PEND  = 8'b1000_0000
    } t_mode;

    typedef enum logic [2:0] {
        OP_EQ    = 3'd0,
        OP_SLASH = 3'd1,
        OP_BANG  = 3'd2,
        OP_LT    = 3'd3,
        OP_GT    = 3'd4,
        OP_BAR   = 3'd5,
        OP_AMP   = 3'd6
    } t_op;

    typedef struct packed {
        logic    hit;
        t_result r;
        t_mode   mode;
        logic    op_we;
        t_op     op;
    } t_disp;

    typedef struct packed {
        logic    has0;
        logic    has1;
        t_result r0;
        t_result r1;
        t_mode   mode;
    } t_sb;

    function automatic t_result mk(logic [4:0] kind, logic [7:0] value, logic text,
                                   logic [1:0] err);
        t_result r;
        r.kind  = kind;
        r.value = value;
        r.text  = text;
        r.err   = err;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic [7:0] exp_char(logic [IDX_W-1:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = CH_QUOTE;
            3'd1:    c = CH_COMMA;
            3'd2:    c = CH_SPACE;
            3'd3:    c = CH_ZERO;
            3'd4:    c = CH_LOWER_X;
            3'd5:    c = CH_LOWER_A;
            3'd6:    c = CH_COMMA;
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] op_first(t_op p);
        logic [7:0] c;
        unique case (p)
            OP_EQ:    c = CH_EQ;
            OP_SLASH: c = CH_SLASH;
            OP_BANG:  c = CH_BANG;
            OP_LT:    c = CH_LT;
            OP_GT:    c = CH_GT;
            OP_BAR:   c = CH_BAR;
            OP_AMP:   c = CH_AMP;
            default:  c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic op_second_hit(t_op p, logic [7:0] b);
        logic h;
        unique case (p)
            OP_EQ, OP_BANG, OP_LT, OP_GT: h = (b == CH_EQ);
            OP_SLASH:                     h = (b == CH_SLASH);
            OP_BAR:                       h = (b == CH_BAR);
            OP_AMP:                       h = (b == CH_AMP);
            default:                      h = 1'b0;
        endcase
        return h;
    endfunction

    function automatic logic [4:0] op_double(t_op p);
        logic [4:0] k;
        unique case (p)
            OP_EQ:   k = K_EQEQ;
            OP_BANG: k = K_NE;
            OP_LT:   k = K_LE;
            OP_GT:   k = K_GE;
            OP_BAR:  k = K_OROR;
            OP_AMP:  k = K_ANDAND;
            default: k = K_SLASH;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] op_single(t_op p);
        logic [4:0] k;
        unique case (p)
            OP_EQ:    k = K_ASSIGN;
            OP_SLASH: k = K_SLASH;
            OP_BANG:  k = K_NOT;
            OP_LT:    k = K_LT;
            OP_GT:    k = K_GT;
            default:  k = K_IDENT;
        endcase
        return k;
    endfunction

    function automatic t_disp dispatch(logic [7:0] b);
        t_disp d;
        d.hit   = 1'b0;
        d.r     = '0;
        d.mode  = M_IDLE;
        d.op_we = 1'b0;
        d.op    = OP_EQ;
        if (is_space(b)) begin
            d.hit = 1'b0;
        end else if (is_alpha(b) || b == CH_UNDER) begin
            d.hit  = 1'b1;
            d.r    = mk(K_IDENT, b, 1'b1, E_NONE);
            d.mode = M_IDENT;
        end else if (is_digit(b)) begin
            d.hit  = 1'b1;
            d.r    = mk(K_INT, b, 1'b1, E_NONE);
            d.mode = M_INT;
        end else if (b == CH_QUOTE) begin
            d.mode = M_STR;
        end else begin
            d.hit = 1'b1;
            case (b)
                CH_LPAREN:  d.r = mk(K_LPAREN, CH_NUL, 1'b0, E_NONE);
                CH_RPAREN:  d.r = mk(K_RPAREN, CH_NUL, 1'b0, E_NONE);
                CH_LBRACE:  d.r = mk(K_LBRACE, CH_NUL, 1'b0, E_NONE);
                CH_RBRACE:  d.r = mk(K_RBRACE, CH_NUL, 1'b0, E_NONE);
                CH_SEMI:    d.r = mk(K_SEMI, CH_NUL, 1'b0, E_NONE);
                CH_COMMA:   d.r = mk(K_COMMA, CH_NUL, 1'b0, E_NONE);
                CH_PLUS:    d.r = mk(K_PLUS, CH_NUL, 1'b0, E_NONE);
                CH_MINUS:   d.r = mk(K_MINUS, CH_NUL, 1'b0, E_NONE);
                CH_STAR:    d.r = mk(K_STAR, CH_NUL, 1'b0, E_NONE);
                CH_PERCENT: d.r = mk(K_PERCENT, CH_NUL, 1'b0, E_NONE);
                CH_NUL:     d.r = mk(K_EOF, CH_NUL, 1'b0, E_NONE);
                CH_EQ, CH_SLASH, CH_BANG, CH_LT, CH_GT, CH_BAR, CH_AMP: begin
                    d.hit   = 1'b0;
                    d.mode  = M_PEND;
                    d.op_we = 1'b1;
                    case (b)
                        CH_EQ:    d.op = OP_EQ;
                        CH_SLASH: d.op = OP_SLASH;
                        CH_BANG:  d.op = OP_BANG;
                        CH_LT:    d.op = OP_LT;
                        CH_GT:    d.op = OP_GT;
                        CH_BAR:   d.op = OP_BAR;
                        default:  d.op = OP_AMP;
                    endcase
                end
                default:    d.r = mk(K_IDENT, b, 1'b0, E_CHAR);
            endcase
        end
        return d;
    endfunction

    function automatic t_sb string_byte(logic [7:0] b);
        t_sb s;
        s.has0 = 1'b0;
        s.has1 = 1'b0;
        s.r0   = '0;
        s.r1   = '0;
        s.mode = M_STR;
        if (b == CH_QUOTE) begin
            s.has0 = 1'b1;
            s.r0   = mk(K_STR, CH_NUL, 1'b0, E_NONE);
            s.mode = M_IDLE;
        end else if (b == CH_NUL) begin
            s.has0 = 1'b1;
            s.has1 = 1'b1;
            s.r0   = mk(K_STR, CH_NUL, 1'b0, E_STRING);
            s.r1   = mk(K_EOF, CH_NUL, 1'b0, E_NONE);
            s.mode = M_IDLE;
        end else if (b == CH_BSLASH) begin
            s.mode = M_ESC;
        end else begin
            s.has0 = 1'b1;
            s.r0   = mk(K_STR, b, 1'b1, E_NONE);
        end
        return s;
    endfunction

endpackage

/* design/st_lex.sv */
module st_lex (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [7:0]                   i_byte,
    output st_pkg::t_res_list            o_res,
    output logic [st_pkg::CNT_W-1:0]     o_cnt
);

    st_pkg::t_mode             r_mode;
    st_pkg::t_mode             n_mode;
    st_pkg::t_op               r_op;
    st_pkg::t_op               n_op;
    st_pkg::t_res_list         res;
    logic [st_pkg::CNT_W-1:0]  cnt;
    st_pkg::t_disp             d;
    st_pkg::t_sb               s;
    logic                      use_d;
    logic                      use_s;

    always_comb begin
        res    = '0;
        cnt    = '0;
        n_mode = r_mode;
        n_op   = r_op;
        use_d  = 1'b0;
        use_s  = 1'b0;
        d      = st_pkg::dispatch(i_byte);
        s      = st_pkg::string_byte(i_byte);
        unique case (r_mode)
            st_pkg::M_IDENT: begin
                if (st_pkg::is_alpha(i_byte) || st_pkg::is_digit(i_byte) ||
                    i_byte == st_pkg::CH_UNDER) begin
                    res[cnt[st_pkg::IDX_W-1:0]] =
                        st_pkg::mk(st_pkg::K_IDENT, i_byte, 1'b1, st_pkg::E_NONE);
                    cnt = cnt + 1'b1;
                end else begin
                    res[cnt[st_pkg::IDX_W-1:0]] =
                        st_pkg::mk(st_pkg::K_IDENT, st_pkg::CH_NUL, 1'b0, st_pkg::E_NONE);
                    cnt   = cnt + 1'b1;
                    use_d = 1'b1;
                end
            end
            st_pkg::M_INT: begin
                if (st_pkg::is_digit(i_byte)) begin
                    res[cnt[st_pkg::IDX_W-1:0]] =
                        st_pkg::mk(st_pkg::K_INT, i_byte, 1'b1, st_pkg::E_NONE);
                    cnt = cnt + 1'b1;
                end else begin
                    res[cnt[st_pkg::IDX_W-1:0]] =
                        st_pkg::mk(st_pkg::K_INT, st_pkg::CH_NUL, 1'b0, st_pkg::E_NONE);
                    cnt   = cnt + 1'b1;
                    use_d = 1'b1;
                end
            end
            st_pkg::M_STR: begin
                use_s = 1'b1;
            end
            st_pkg::M_ESC: begin
                if (i_byte == st_pkg::CH_LOWER_N) begin
                    for (int i = 0; i < st_pkg::MAX_RES; i++) begin
                        res[i] = st_pkg::mk(st_pkg::K_STR,
                                            st_pkg::exp_char(i[st_pkg::IDX_W-1:0]),
                                            1'b1, st_pkg::E_NONE);
                    end
                    cnt    = st_pkg::CNT_W'(st_pkg::MAX_RES);
                    n_mode = st_pkg::M_OWE;
                end else begin
                    res[cnt[st_pkg::IDX_W-1:0]] =
                        st_pkg::mk(st_pkg::K_STR, st_pkg::CH_BSLASH, 1'b1, st_pkg::E_NONE);
                    cnt   = cnt + 1'b1;
                    use_s = 1'b1;
                end
            end
            st_pkg::M_OWE: begin
                res[cnt[st_pkg::IDX_W-1:0]] =
                    st_pkg::mk(st_pkg::K_STR, st_pkg::CH_QUOTE, 1'b1, st_pkg::E_NONE);
                cnt   = cnt + 1'b1;
                use_s = 1'b1;
            end
            st_pkg::M_CMT: begin
                if (i_byte == st_pkg::CH_NL) begin
                    n_mode = st_pkg::M_IDLE;
                end else if (i_byte == st_pkg::CH_NUL) begin
                    res[cnt[st_pkg::IDX_W-1:0]] =
                        st_pkg::mk(st_pkg::K_EOF, st_pkg::CH_NUL, 1'b0, st_pkg::E_NONE);
                    cnt    = cnt + 1'b1;
                    n_mode = st_pkg::M_IDLE;
                end
            end
            st_pkg::M_PEND: begin
                if (st_pkg::op_second_hit(r_op, i_byte)) begin
                    if (r_op == st_pkg::OP_SLASH) begin
                        n_mode = st_pkg::M_CMT;
                    end else begin
                        res[cnt[st_pkg::IDX_W-1:0]] = st_pkg::mk(st_pkg::op_double(r_op),
                            st_pkg::CH_NUL, 1'b0, st_pkg::E_NONE);
                        cnt    = cnt + 1'b1;
                        n_mode = st_pkg::M_IDLE;
                    end
                end else begin
                    if (r_op == st_pkg::OP_BAR || r_op == st_pkg::OP_AMP) begin
                        res[cnt[st_pkg::IDX_W-1:0]] = st_pkg::mk(st_pkg::K_IDENT,
                            st_pkg::op_first(r_op), 1'b0, st_pkg::E_CHAR);
                    end else begin
                        res[cnt[st_pkg::IDX_W-1:0]] = st_pkg::mk(st_pkg::op_single(r_op),
                            st_pkg::CH_NUL, 1'b0, st_pkg::E_NONE);
                    end
                    cnt   = cnt + 1'b1;
                    use_d = 1'b1;
                end
            end
            default: begin
                use_d = 1'b1;
            end
        endcase

        if (use_d) begin
            if (d.hit) begin
                res[cnt[st_pkg::IDX_W-1:0]] = d.r;
                cnt = cnt + 1'b1;
            end
            n_mode = d.mode;
            if (d.op_we) begin
                n_op = d.op;
            end
        end
        if (use_s) begin
            if (s.has0) begin
                res[cnt[st_pkg::IDX_W-1:0]] = s.r0;
                cnt = cnt + 1'b1;
            end
            if (s.has1) begin
                res[cnt[st_pkg::IDX_W-1:0]] = s.r1;
                cnt = cnt + 1'b1;
            end
            n_mode = s.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= st_pkg::M_IDLE;
            r_op   <= st_pkg::OP_EQ;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_op   <= n_op;
        end
    end

    assign o_res = res;
    assign o_cnt = cnt;

endmodule

/* design/st_outbuf.sv */
module st_outbuf (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  st_pkg::t_res_list            i_res,
    input  logic [st_pkg::CNT_W-1:0]     i_cnt,
    output logic                         o_free,
    output logic                         o_valid,
    input  logic                         i_ready,
    output st_pkg::t_result              o_result,
    output logic                         o_last
);

    st_pkg::t_res_list         r_buf;
    logic [st_pkg::CNT_W-1:0]  r_rem;
    logic [st_pkg::IDX_W-1:0]  r_idx;

    assign o_valid  = (r_rem != '0);
    assign o_last   = (r_rem == st_pkg::CNT_W'(1));
    assign o_result = r_buf[r_idx];
    assign o_free   = (r_rem == '0) || (o_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_rem <= i_cnt;
            r_idx <= '0;
        end else if (o_valid && i_ready) begin
            r_rem <= r_rem - 1'b1;
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_res;
        end
    end

endmodule

/* design/source_tokenizer.sv */
// Byte-serial tokenizer for source text.
// The slave channel takes one text byte per transaction in tdata; a zero byte ends the text.
// The master channel gives one result per transaction: tdata carries the token character,
// tuser the kind, the text flag and the error code, and tlast marks the final result
// that a given input byte caused. A byte may cause no result at all.
// An accepted byte is held in an input register; once the result buffer is free, the tokenizer
// logic decodes it against the current mode and loads every result it causes into a result
// buffer of eight entries, from which the results are presented.
// The buffer drains one result per cycle while the receiver is ready. A byte that causes zero
// or one result does not hold off the next, so ordinary text then streams at one byte per cycle;
// a byte that causes more holds the buffer until all leave, up to eight for the newline escape.
// A new byte is loaded into the buffer while the previous results are still in it, as long as
// the last of them leaves in the same cycle.
// When the receiver stalls, the buffer holds, and at most one further byte is taken
// into the input register before tready falls.
// Reset (synchronous, active low) empties both registers and returns the tokenizer to
// the idle mode between tokens.
module source_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] text_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] value_byte
    output logic [7:0] o_m_axis_tuser,   // [4:0] token_kind, [5] is_text_byte, [7:6] error_code
    output logic       o_m_axis_tlast    // last_of_run
);

    logic                      r_in_valid;
    logic                      n_in_valid;
    logic [7:0]                r_in_byte;
    logic                      accept;
    logic                      load;
    logic                      buf_free;
    st_pkg::t_res_list         step_res;
    logic [st_pkg::CNT_W-1:0]  step_cnt;
    st_pkg::t_result           out_res;

    assign load            = r_in_valid && buf_free;
    assign o_s_axis_tready = !r_in_valid || load;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (load) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    st_lex u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (load),
        .i_byte  (r_in_byte),
        .o_res   (step_res),
        .o_cnt   (step_cnt)
    );

    st_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_res    (step_res),
        .i_cnt    (step_cnt),
        .o_free   (buf_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_res),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = out_res.value;
    assign o_m_axis_tuser = {out_res.err, out_res.text, out_res.kind};

endmodule
